// File: src/qrv_pkg.sv
`default_nettype none

package qrv_pkg;

  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QUAT_W = 4'd0,
    REG_QUAT_X = 4'd1,
    REG_QUAT_Y = 4'd2,
    REG_QUAT_Z = 4'd3
  } qrv_reg_e;

  typedef struct packed {
    logic degenerate;
    logic saturated;
  } qrv_flags_t;

endpackage

`default_nettype wire

// File: src/quaternion_rotate_vector_unit.sv
// channel   dir  words                               handshake
// s_axis    in   tdata: vec_x, vec_y, vec_z          tvalid / tready
// m_axis    out  tdata: rot_x, rot_y, rot_z          tvalid / tready
//                tuser: saturated, degenerate
// cfg       in   index 0..3: quat_w, quat_x, y, z    cfg_valid_i / cfg_ready_o (always high)
//
// One word per cycle while m_axis is not stalled; the divider resolves one quotient
// bit per stage.
// Reset clears all valid bits and loads the identity quaternion.
// Each stage holds while its successor is full and stalled; empty stages fill.
`default_nettype none

module quaternion_rotate_vector_unit import qrv_pkg::*; #(
  parameter int unsigned VEC_WIDTH  = 32,
  parameter int unsigned QUAT_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [((3*VEC_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // vec_x, vec_y, vec_z
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_axis_tdata,  // rot_x, rot_y, rot_z
  output      logic [1:0]             m_axis_tuser,  // saturated, degenerate
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [QUAT_WIDTH-1:0]  cfg_data_i
);

  localparam int unsigned VW   = VEC_WIDTH;
  localparam int unsigned QW   = QUAT_WIDTH;
  localparam int unsigned PW   = 2 * QW;
  localparam int unsigned MW   = 2 * QW + 2;
  localparam int unsigned NW   = 2 * QW + 1;
  localparam int unsigned NUMW = 2 * QW + VW + 2;
  localparam int unsigned LW   = QW + 1;
  localparam int unsigned PHW  = MW - LW + VW;
  localparam int unsigned PLW  = LW + 1 + VW;
  localparam int unsigned TDW  = ((3 * VW + 7) / 8) * 8;

  logic signed [QW-1:0] q_q [4];

  logic                 v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                 en1, en2, en3, en4, en5;
  logic                 div_rdy;

  logic signed [VW-1:0] vec1_q [3];
  logic signed [VW-1:0] vec2_q [3];
  logic signed [PW-1:0] pww_q, pxx_q, pyy_q, pzz_q, pwx_q, pwy_q, pwz_q, pxy_q, pxz_q, pyz_q;
  logic signed [MW-1:0] m2_q [3][3];
  logic [NW-1:0]        n2_q, n3_q, n4_q, n5_q;
  logic signed [PHW-1:0] ph3_q [3][3];
  logic signed [PLW-1:0] pl3_q [3][3];
  logic signed [NUMW-1:0] pr4_q [3][3];
  logic [NUMW-1:0]      num5_q [3];

  logic [VW-1:0]        rot [3];
  qrv_flags_t           flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= {2'b01, {(QW-2){1'b0}}};
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= '0;
    end else if (cfg_valid_i) begin
      case (qrv_reg_e'(cfg_index_i))
        REG_QUAT_W: q_q[0] <= cfg_data_i;
        REG_QUAT_X: q_q[1] <= cfg_data_i;
        REG_QUAT_Y: q_q[2] <= cfg_data_i;
        REG_QUAT_Z: q_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en5 = !v5_q || div_rdy;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // quaternion component products
  always_ff @(posedge clk_i) begin
    if (en1) begin
      vec1_q[0] <= s_axis_tdata[VW-1:0];
      vec1_q[1] <= s_axis_tdata[2*VW-1:VW];
      vec1_q[2] <= s_axis_tdata[3*VW-1:2*VW];
      pww_q <= q_q[0] * q_q[0];
      pxx_q <= q_q[1] * q_q[1];
      pyy_q <= q_q[2] * q_q[2];
      pzz_q <= q_q[3] * q_q[3];
      pwx_q <= q_q[0] * q_q[1];
      pwy_q <= q_q[0] * q_q[2];
      pwz_q <= q_q[0] * q_q[3];
      pxy_q <= q_q[1] * q_q[2];
      pxz_q <= q_q[1] * q_q[3];
      pyz_q <= q_q[2] * q_q[3];
    end
  end

  // unnormalised rotation matrix and squared norm
  always_ff @(posedge clk_i) begin
    if (en2) begin
      vec2_q <= vec1_q;
      m2_q[0][0] <= MW'(pww_q) + MW'(pxx_q) - MW'(pyy_q) - MW'(pzz_q);
      m2_q[1][1] <= MW'(pww_q) - MW'(pxx_q) + MW'(pyy_q) - MW'(pzz_q);
      m2_q[2][2] <= MW'(pww_q) - MW'(pxx_q) - MW'(pyy_q) + MW'(pzz_q);
      m2_q[0][1] <= (MW'(pxy_q) + MW'(pwz_q)) <<< 1;
      m2_q[0][2] <= (MW'(pxz_q) - MW'(pwy_q)) <<< 1;
      m2_q[1][0] <= (MW'(pxy_q) - MW'(pwz_q)) <<< 1;
      m2_q[1][2] <= (MW'(pyz_q) + MW'(pwx_q)) <<< 1;
      m2_q[2][0] <= (MW'(pxz_q) + MW'(pwy_q)) <<< 1;
      m2_q[2][1] <= (MW'(pyz_q) - MW'(pwx_q)) <<< 1;
      n2_q <= NW'(MW'(pww_q) + MW'(pxx_q) + MW'(pyy_q) + MW'(pzz_q));
    end
  end

  // split partial products, upper signed half and lower unsigned half
  always_ff @(posedge clk_i) begin
    if (en3) begin
      n3_q <= n2_q;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          ph3_q[k][j] <= $signed(m2_q[k][j][MW-1:LW]) * vec2_q[j];
          pl3_q[k][j] <= $signed({1'b0, m2_q[k][j][LW-1:0]}) * vec2_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      n4_q <= n3_q;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pr4_q[k][j] <= (NUMW'(ph3_q[k][j]) <<< LW) + NUMW'(pl3_q[k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      n5_q <= n4_q;
      for (int k = 0; k < 3; k++) begin
        num5_q[k] <= pr4_q[k][0] + pr4_q[k][1] + pr4_q[k][2];
      end
    end
  end

  qrv_div #(
    .VW   (VW),
    .NW   (NW),
    .NUMW (NUMW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_ready_o  (div_rdy),
    .num_i       (num5_q),
    .den_i       (n5_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rot_o       (rot),
    .flags_o     (flags)
  );

  assign m_axis_tdata = TDW'({rot[2], rot[1], rot[0]});
  assign m_axis_tuser = flags;

endmodule

`default_nettype wire

// File: src/qrv_div.sv
`default_nettype none

module qrv_div import qrv_pkg::*; #(
  parameter int unsigned VW   = 32,
  parameter int unsigned NW   = 65,
  parameter int unsigned NUMW = 98
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire logic [NUMW-1:0] num_i [3],
  input  wire logic [NW-1:0]   den_i,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      logic [VW-1:0]   rot_o [3],
  output      qrv_flags_t      flags_o
);

  localparam int unsigned STEPS = VW + 1;
  localparam logic [STEPS:0] LimPos = (STEPS+1)'(1) << (VW - 1);

  logic            va_q;
  logic            en_a;
  logic [2:0]      nga_q;
  logic [NUMW-1:0] mag_q [3];
  logic [NW-1:0]   dena_q;
  logic            dga_q;

  logic            vl_q  [STEPS+1];
  logic            en_st [STEPS+1];
  logic [NW-1:0]   rem_q [STEPS+1][3];
  logic [STEPS-1:0] lq_q [STEPS+1][3];
  logic [2:0]      ng_q  [STEPS+1];
  logic [2:0]      ovf_q [STEPS+1];
  logic [NW-1:0]   den_q [STEPS+1];
  logic            dg_q  [STEPS+1];

  logic            ov_q;
  logic            en_out;
  logic [VW-1:0]   rot_d [3];
  logic [VW-1:0]   rot_q [3];
  qrv_flags_t      flags_d;
  qrv_flags_t      flags_q;

  assign en_out     = !ov_q || out_ready_i;
  assign en_a       = !va_q || en_st[0];
  assign in_ready_o = en_a;

  // magnitude and sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      for (int k = 0; k < 3; k++) begin
        nga_q[k] <= num_i[k][NUMW-1];
        mag_q[k] <= num_i[k][NUMW-1] ? (NUMW'(0) - num_i[k]) : num_i[k];
      end
      dena_q <= den_i;
      dga_q  <= (den_i == '0);
    end
  end

  // overflow check on the upper bits, then seed the remainder
  assign en_st[0] = !vl_q[0] || en_st[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q[0] <= 1'b0;
    end else if (en_st[0]) begin
      vl_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_st[0]) begin
      for (int k = 0; k < 3; k++) begin
        ovf_q[0][k] <= (mag_q[k][NUMW-1:VW+1] >= dena_q);
        rem_q[0][k] <= (mag_q[k][NUMW-1:VW+1] >= dena_q) ? '0 : mag_q[k][NUMW-1:VW+1];
        lq_q[0][k]  <= mag_q[k][VW:0];
      end
      ng_q[0]  <= nga_q;
      den_q[0] <= dena_q;
      dg_q[0]  <= dga_q;
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    logic [NW:0] t    [3];
    logic [NW:0] tsub [3];
    logic [2:0]  ge;

    if (s == STEPS) begin : g_last
      assign en_st[s] = !vl_q[s] || en_out;
    end else begin : g_mid
      assign en_st[s] = !vl_q[s] || en_st[s+1];
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      assign t[k]    = {rem_q[s-1][k], lq_q[s-1][k][STEPS-1]};
      assign ge[k]   = (t[k] >= {1'b0, den_q[s-1]});
      assign tsub[k] = t[k] - {1'b0, den_q[s-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q[s] <= 1'b0;
      end else if (en_st[s]) begin
        vl_q[s] <= vl_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_st[s]) begin
        for (int k = 0; k < 3; k++) begin
          rem_q[s][k] <= ge[k] ? tsub[k][NW-1:0] : t[k][NW-1:0];
          lq_q[s][k]  <= {lq_q[s-1][k][STEPS-2:0], ge[k]};
        end
        ng_q[s]  <= ng_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        den_q[s] <= den_q[s-1];
        dg_q[s]  <= dg_q[s-1];
      end
    end
  end

  // round half away from zero, then clip; a zero norm gives zero with no saturation flag
  always_comb begin
    logic [STEPS:0] q;
    logic           up;
    logic           sat;
    flags_d = '0;
    for (int k = 0; k < 3; k++) begin
      up  = ({rem_q[STEPS][k], 1'b0} >= {1'b0, den_q[STEPS]});
      q   = {1'b0, lq_q[STEPS][k]} + (STEPS+1)'(up);
      sat = ovf_q[STEPS][k] || (ng_q[STEPS][k] ? (q > LimPos) : (q >= LimPos));
      if (sat) begin
        rot_d[k] = ng_q[STEPS][k] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      end else begin
        rot_d[k] = ng_q[STEPS][k] ? (VW'(0) - q[VW-1:0]) : q[VW-1:0];
      end
      flags_d.saturated = flags_d.saturated || sat;
      if (dg_q[STEPS]) begin
        rot_d[k] = '0;
      end
    end
    if (dg_q[STEPS]) begin
      flags_d.saturated = 1'b0;
    end
    flags_d.degenerate = dg_q[STEPS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_out) begin
      ov_q <= vl_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      rot_q   <= rot_d;
      flags_q <= flags_d;
    end
  end

  assign out_valid_o = ov_q;
  assign rot_o       = rot_q;
  assign flags_o     = flags_q;

endmodule

`default_nettype wire

// File: src/qrv_checker.sv
`default_nettype none

module qrv_checker import qrv_pkg::*; #(
  parameter int unsigned VEC_WIDTH  = 32,
  parameter int unsigned QUAT_WIDTH = 32
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input wire logic [1:0]             m_axis_tuser,
  input wire logic                   cfg_valid_i,
  input wire logic                   cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word dropped or changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0) && !m_axis_tuser[0])
    else $error("degenerate word carries data or saturation");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write refused");

  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && $past(!m_axis_tvalid) |-> s_axis_tready || !s_axis_tvalid
      || $past(s_axis_tvalid && !s_axis_tready) || $past(s_axis_tvalid))
    else $error("input stalled with an empty output");

endmodule

bind quaternion_rotate_vector_unit qrv_checker #(
  .VEC_WIDTH  (VEC_WIDTH),
  .QUAT_WIDTH (QUAT_WIDTH)
) u_qrv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire
